>>> hdl/lvm_pkg.sv
// Shared constants, types and helpers for the view matrix block.
`default_nettype none
package lvm_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int ANG_W = 16;
  localparam int POS_W = 32;
  localparam int ELEM_W = 32;
  localparam int Q_W = 34;
  localparam int TERMS = 8;
  localparam logic [33:0] Q_ONE = 34'd1073741824;
  localparam logic [33:0] Q_PI = 34'd3373259426;
  localparam logic [33:0] Q_HALF_PI = 34'd1686629713;
  localparam logic [34:0] Q_TWO_PI = 35'd6746518852;
  localparam logic [1:0] ROW_LAST = 2'd3;

  typedef logic signed [Q_W-1:0] q_t;

  typedef struct packed {
    logic sneg;
    logic cneg;
  } sc_sign_t;

  // 68-bit signed product rounded to Q30, halves away from zero
  function automatic q_t qmul(input q_t a, input q_t b);
    logic signed [67:0] p;
    logic [67:0] mag;
    logic neg;
    p = a * b;
    neg = p[67];
    mag = neg ? -p : p;
    mag = (mag + (68'd1 << 29)) >> 30;
    qmul = neg ? -q_t'(mag[Q_W-1:0]) : q_t'(mag[Q_W-1:0]);
  endfunction

  // reciprocal of the series divisor in Q40 for term k of sine/cosine
  function automatic logic [40:0] recip(input int d);
    recip = 41'((64'd1 << 40) / 64'(d) + 64'd1);
  endfunction
endpackage
`default_nettype wire

>>> hdl/lvm_sincos.sv
// Pipelined sine/cosine lane: fold, then one Horner step per two stages.
`default_nettype none
module lvm_sincos (
  input  wire logic clk,
  input  wire logic                             en,
  input  wire logic signed [lvm_pkg::ANG_W-1:0] ang,
  output lvm_pkg::q_t                           sin_o,
  output lvm_pkg::q_t                           cos_o
);
  import lvm_pkg::*;

  logic [33:0] m_a, m_b;
  logic [16:0] amag;
  logic [34:0] m0;
  logic sn, cn;

  logic [33:0] m_r [0:TERMS];
  logic [33:0] x2_r [0:TERMS];
  logic [33:0] sb_r [0:TERMS];
  logic [33:0] cb_r [0:TERMS];
  sc_sign_t sg_r [0:TERMS];
  q_t sin_r, cos_r;

  always_comb begin
    amag = ang[ANG_W-1] ? 17'(-$signed({ang[ANG_W-1], ang})) : 17'(ang);
    m0 = 35'(amag) << 17;
    sn = ang[ANG_W-1];
    m_a = m0[33:0];
    if (m0 > 35'(Q_PI)) begin
      m_a = 34'(Q_TWO_PI - m0);
      sn = ~sn;
    end
    cn = 1'b0;
    m_b = m_a;
    if (m_a > Q_HALF_PI) begin
      m_b = Q_PI - m_a;
      cn = 1'b1;
    end
  end

  // stage 0: fold and square
  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0] <= m_b;
      x2_r[0] <= 34'((68'(m_b) * 68'(m_b)) >> 30);
      sb_r[0] <= Q_ONE;
      cb_r[0] <= Q_ONE;
      sg_r[0] <= '{sneg: sn, cneg: cn};
    end
  end

  // Horner steps, k from 8 down to 1; division by constant via reciprocal
  for (genvar g = 0; g < TERMS; g++) begin : g_step
    localparam int K = TERMS - g;
    localparam int DS = (2*K)*(2*K+1);
    localparam int DC = (2*K-1)*(2*K);
    logic [67:0] ps, pc;
    logic [33:0] ts_r, tc_r, mh_r, x2h_r, qs, qc;
    sc_sign_t sgh_r;
    logic [75:0] es, ec;

    // first half: scale the running brackets by x^2
    assign ps = 68'(x2_r[g]) * 68'(sb_r[g]);
    assign pc = 68'(x2_r[g]) * 68'(cb_r[g]);
    always_ff @(posedge clk) begin
      ts_r <= 34'(ps >> 30);
      tc_r <= 34'(pc >> 30);
      mh_r <= m_r[g];
      x2h_r <= x2_r[g];
      sgh_r <= sg_r[g];
    end

    // second half: divide by the series constant, floor the quotient and clamp the bracket at zero
    always_comb begin
      es = 76'(ts_r) * 76'(recip(DS));
      ec = 76'(tc_r) * 76'(recip(DC));
      qs = 34'(es >> 40);
      qc = 34'(ec >> 40);
      if (68'(qs) * DS > 68'(ts_r)) qs = qs - 34'd1;
      if (68'(qc) * DC > 68'(tc_r)) qc = qc - 34'd1;
    end
    always_ff @(posedge clk) begin
      m_r[g+1] <= mh_r;
      x2_r[g+1] <= x2h_r;
      sg_r[g+1] <= sgh_r;
      sb_r[g+1] <= (qs > Q_ONE) ? '0 : Q_ONE - qs;
      cb_r[g+1] <= (qc > Q_ONE) ? '0 : Q_ONE - qc;
    end
  end

  logic [67:0] sf;
  logic [33:0] sv;
  assign sf = 68'(m_r[TERMS]) * 68'(sb_r[TERMS]);
  assign sv = 34'(sf >> 30);

  always_ff @(posedge clk) begin
    sin_r <= sg_r[TERMS].sneg ? -q_t'(sv) : q_t'(sv);
    cos_r <= sg_r[TERMS].cneg ? -q_t'(cb_r[TERMS]) : q_t'(cb_r[TERMS]);
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;
endmodule
`default_nettype wire

>>> hdl/lvm_merge.sv
// Merge stage: combine lane outputs into rotation and stream rows.
`default_nettype none
module lvm_merge #(
  parameter int FRACTION_BITS = lvm_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        go,
  input  wire lvm_pkg::q_t sa, ca, sb, cb, sr, cr,
  input  wire logic signed [lvm_pkg::POS_W-1:0] px, py, pz,
  output logic             strobe,
  output logic signed [lvm_pkg::ELEM_W-1:0] c0, c1, c2, c3,
  output logic [1:0]       row,
  output logic             last
);
  import lvm_pkg::*;
  localparam int RSH = 30 - FRACTION_BITS;

  // stage A: pair products
  q_t ab_r, cbs_r, cacr_r, casr_r, sacr_r, sasr_r, sacb_r, cbsr_r, cbcr_r, cacb_r;
  q_t sb_a, cr_a, sr_a;
  logic va_r, vb_r;
  logic signed [POS_W-1:0] p_a [3], p_b [3];
  always_ff @(posedge clk) begin
    ab_r <= qmul(sa, sb);
    cbs_r <= qmul(ca, sb);
    cacr_r <= qmul(ca, cr);
    casr_r <= qmul(ca, sr);
    sacr_r <= qmul(sa, cr);
    sasr_r <= qmul(sa, sr);
    sacb_r <= qmul(sa, cb);
    cbsr_r <= qmul(cb, sr);
    cbcr_r <= qmul(cb, cr);
    cacb_r <= qmul(ca, cb);
    sb_a <= sb; cr_a <= cr; sr_a <= sr;
    p_a[0] <= px; p_a[1] <= py; p_a[2] <= pz;
  end

  // stage B: rotation entries
  q_t r_r [3][3];
  always_ff @(posedge clk) begin
    r_r[0][0] <= cacr_r + qmul(ab_r, sr_a);
    r_r[0][1] <= -casr_r + qmul(ab_r, cr_a);
    r_r[0][2] <= sacb_r;
    r_r[1][0] <= cbsr_r;
    r_r[1][1] <= cbcr_r;
    r_r[1][2] <= -sb_a;
    r_r[2][0] <= -sacr_r + qmul(cbs_r, sr_a);
    r_r[2][1] <= sasr_r + qmul(cbs_r, cr_a);
    r_r[2][2] <= cacb_r;
    p_b <= p_a;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= go;
      vb_r <= va_r;
    end
  end

  // row sequencer: hold a snapshot, emit one row per cycle
  q_t h_r [3][3];
  logic signed [POS_W-1:0] hp_r [3];
  logic [1:0] cnt_r, cnt_nxt;
  logic act_r, act_nxt;
  always_ff @(posedge clk) begin
    if (vb_r) begin
      h_r <= r_r;
      hp_r <= p_b;
    end
  end
  always_comb begin
    act_nxt = act_r;
    cnt_nxt = cnt_r;
    if (vb_r) begin
      act_nxt = 1'b1;
      cnt_nxt = '0;
    end else if (act_r) begin
      cnt_nxt = cnt_r + 2'd1;
      if (cnt_r == ROW_LAST) act_nxt = 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      act_r <= act_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  function automatic logic signed [ELEM_W-1:0] rnd(input q_t v);
    logic [Q_W-1:0] m;
    m = v[Q_W-1] ? -v : v;
    m = (m + (Q_W'(1) << (RSH-1))) >> RSH;
    rnd = v[Q_W-1] ? -ELEM_W'(m) : ELEM_W'(m);
  endfunction

  // stage C: translation dot products for the current column
  logic signed [65:0] d0, d1, d2;
  logic signed [67:0] acc;
  logic [1:0] ci;
  always_comb begin
    ci = (cnt_r == ROW_LAST) ? 2'd0 : cnt_r;
    d0 = h_r[0][ci] * hp_r[0];
    d1 = h_r[1][ci] * hp_r[1];
    d2 = h_r[2][ci] * hp_r[2];
    acc = -(68'(d0) + 68'(d1) + 68'(d2));
  end

  logic signed [67:0] acc_r;
  logic signed [ELEM_W-1:0] e0_r, e1_r, e2_r;
  logic [1:0] row_r;
  logic last_r, vc_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vc_r <= 1'b0;
    else vc_r <= act_r;
    acc_r <= acc;
    e0_r <= rnd(h_r[0][ci]);
    e1_r <= rnd(h_r[1][ci]);
    e2_r <= rnd(h_r[2][ci]);
    row_r <= cnt_r;
    last_r <= (cnt_r == ROW_LAST);
  end

  // round the translation sum to Q.F
  logic [67:0] am;
  logic signed [68:0] t;
  always_comb begin
    am = acc_r[67] ? -acc_r : acc_r;
    am = (am + (68'd1 << 29)) >> 30;
    t = acc_r[67] ? -$signed({1'b0, am}) : $signed({1'b0, am});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) strobe <= 1'b0;
    else strobe <= vc_r;
    row <= row_r;
    last <= last_r;
    if (last_r) begin
      c0 <= '0; c1 <= '0; c2 <= '0;
      c3 <= ELEM_W'(1) << FRACTION_BITS;
    end else begin
      c0 <= e0_r;
      c1 <= e1_r;
      c2 <= e2_r;
      if (t > 69'sd2147483647) c3 <= 32'sh7fffffff;
      else if (t < -69'sd2147483648) c3 <= 32'sh80000000;
      else c3 <= ELEM_W'(t);
    end
  end
endmodule
`default_nettype wire

>>> hdl/look_in_direction_view_matrix_top.sv
// Top level: three sine/cosine lanes feeding the matrix merge stage.
`default_nettype none
// A new request is accepted only while busy is low (busy rises after the
// accepting edge and holds off further requests); row 0 reaches the outputs
// after the lane pipelines and merge stages, then rows 1..3 on consecutive
// cycles marked by out_valid. The four-row output stream sets the request rate.
// Results cannot be held off and must be taken as they appear.
module look_in_direction_view_matrix_top #(
  parameter int FRACTION_BITS = lvm_pkg::FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire logic signed [lvm_pkg::POS_W-1:0] in_pos_x,
  input  wire logic signed [lvm_pkg::POS_W-1:0] in_pos_y,
  input  wire logic signed [lvm_pkg::POS_W-1:0] in_pos_z,
  input  wire logic signed [lvm_pkg::ANG_W-1:0] in_angle_direction,
  input  wire logic signed [lvm_pkg::ANG_W-1:0] in_angle_elevation,
  input  wire logic signed [lvm_pkg::ANG_W-1:0] in_angle_roll,
  output logic      out_valid,
  output logic signed [lvm_pkg::ELEM_W-1:0] out_elem_c0,
  output logic signed [lvm_pkg::ELEM_W-1:0] out_elem_c1,
  output logic signed [lvm_pkg::ELEM_W-1:0] out_elem_c2,
  output logic signed [lvm_pkg::ELEM_W-1:0] out_elem_c3,
  output logic [1:0] out_row_index,
  output logic       out_last_row
);
  import lvm_pkg::*;
  localparam int LAT = 2*TERMS + 2;

  logic acc_w;
  logic [1:0] gap_r, gap_nxt;
  assign acc_w = start && !busy;
  assign busy = (gap_r != 2'd0);
  always_comb begin
    gap_nxt = gap_r;
    if (acc_w) gap_nxt = 2'd3;
    else if (gap_r != 2'd0) gap_nxt = gap_r - 2'd1;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) gap_r <= '0;
    else gap_r <= gap_nxt;
  end

  // delay position and valid alongside the lanes
  logic [LAT-1:0] v_r;
  logic signed [POS_W-1:0] px_r [LAT], py_r [LAT], pz_r [LAT];
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else v_r <= {v_r[LAT-2:0], acc_w};
    px_r[0] <= in_pos_x; py_r[0] <= in_pos_y; pz_r[0] <= in_pos_z;
    for (int i = 1; i < LAT; i++) begin
      px_r[i] <= px_r[i-1]; py_r[i] <= py_r[i-1]; pz_r[i] <= pz_r[i-1];
    end
  end

  q_t sa, ca, sb, cb, sr, cr;
  lvm_sincos u_dir (.clk(clk), .en(1'b1), .ang(in_angle_direction), .sin_o(sa), .cos_o(ca));
  lvm_sincos u_elv (.clk(clk), .en(1'b1), .ang(in_angle_elevation), .sin_o(sb), .cos_o(cb));
  lvm_sincos u_rol (.clk(clk), .en(1'b1), .ang(in_angle_roll), .sin_o(sr), .cos_o(cr));

  lvm_merge #(.FRACTION_BITS(FRACTION_BITS)) u_merge (
    .clk(clk), .rst_n(rst_n), .go(v_r[LAT-1]),
    .sa(sa), .ca(ca), .sb(sb), .cb(cb), .sr(sr), .cr(cr),
    .px(px_r[LAT-1]), .py(py_r[LAT-1]), .pz(pz_r[LAT-1]),
    .strobe(out_valid), .c0(out_elem_c0), .c1(out_elem_c1),
    .c2(out_elem_c2), .c3(out_elem_c3), .row(out_row_index), .last(out_last_row)
  );

`ifndef SYNTH
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    acc_w |=> busy) else $error("busy not raised after request");
  a_last_row3: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_row |-> out_row_index == ROW_LAST)
    else $error("last row flag mismatch");
  a_row_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_row |=> out_valid)
    else $error("row stream broken");
`endif
endmodule
`default_nettype wire

>>> tb/look_in_direction_view_matrix_checker.sv
// Checker for the view matrix block: predicts rows per request and compares outputs.
`timescale 1ns / 1ps
module look_in_direction_view_matrix_checker #(
  parameter int FRACTION_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic busy,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [15:0] in_angle_direction,
  input  logic signed [15:0] in_angle_elevation,
  input  logic signed [15:0] in_angle_roll,
  input  logic out_valid,
  input  logic signed [31:0] out_elem_c0,
  input  logic signed [31:0] out_elem_c1,
  input  logic signed [31:0] out_elem_c2,
  input  logic signed [31:0] out_elem_c3,
  input  logic [1:0] out_row_index,
  input  logic out_last_row,
  output int errors,
  output int pending_rows,
  output int rows_seen,
  output int saturated_rows
);
  typedef struct {
    logic signed [31:0] c0, c1, c2, c3;
    logic [1:0] row;
    logic last;
  } view_row_t;

  localparam longint FX_ONE = 64'sd1 << 30;
  localparam longint FX_PI = 64'sd3373259426;
  localparam longint FX_HALF_PI = 64'sd1686629713;
  localparam longint FX_TWO_PI = 64'sd6746518852;

  view_row_t expected_rows[$];

  // round to nearest, halves away from zero; wide to hold dot products
  function automatic logic signed [127:0] round_away(logic signed [127:0] v, int sh);
    logic signed [127:0] mag;
    logic neg;
    neg = v < 0;
    mag = neg ? -v : v;
    if (sh > 0) mag = (mag + (128'sd1 <<< (sh - 1))) >>> sh;
    return neg ? -mag : mag;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return longint'(round_away(128'(a) * 128'(b), 30));
  endfunction

  function automatic void sin_cos(logic signed [15:0] ang, output longint s, output longint c);
    logic sneg, cneg;
    longint m, x2, sb, cb, ds, dc;
    sneg = ang < 0;
    cneg = 0;
    m = (sneg ? -longint'(ang) : longint'(ang)) * 131072;
    sb = FX_ONE;
    cb = FX_ONE;
    if (m > FX_PI) begin
      m = FX_TWO_PI - m;
      sneg = !sneg;
    end
    if (m > FX_HALF_PI) begin
      m = FX_PI - m;
      cneg = 1;
    end
    x2 = (m * m) >>> 30;
    for (int k = 8; k >= 1; k--) begin
      ds = (2 * k) * (2 * k + 1);
      dc = (2 * k - 1) * (2 * k);
      sb = FX_ONE - ((x2 * sb) >>> 30) / ds;
      cb = FX_ONE - ((x2 * cb) >>> 30) / dc;
      if (sb < 0) sb = 0;
      if (cb < 0) cb = 0;
    end
    sb = (m * sb) >>> 30;
    s = sneg ? -sb : sb;
    c = cneg ? -cb : cb;
  endfunction

  task automatic predict_view_rows();
    longint sa, ca, se, ce, sr, cr;
    longint rot[3][3];
    longint pos[3];
    logic signed [127:0] acc, t;
    view_row_t v;
    pos[0] = in_pos_x;
    pos[1] = in_pos_y;
    pos[2] = in_pos_z;
    sin_cos(in_angle_direction, sa, ca);
    sin_cos(in_angle_elevation, se, ce);
    sin_cos(in_angle_roll, sr, cr);
    rot[0][0] = fx_mul(ca, cr) + fx_mul(fx_mul(sa, se), sr);
    rot[0][1] = -fx_mul(ca, sr) + fx_mul(fx_mul(sa, se), cr);
    rot[0][2] = fx_mul(sa, ce);
    rot[1][0] = fx_mul(ce, sr);
    rot[1][1] = fx_mul(ce, cr);
    rot[1][2] = -se;
    rot[2][0] = -fx_mul(sa, cr) + fx_mul(fx_mul(ca, se), sr);
    rot[2][1] = fx_mul(sa, sr) + fx_mul(fx_mul(ca, se), cr);
    rot[2][2] = fx_mul(ca, ce);
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += 128'(rot[j][i]) * 128'(pos[j]);
      v.c0 = 32'(round_away(128'(rot[0][i]), 30 - FRACTION_BITS));
      v.c1 = 32'(round_away(128'(rot[1][i]), 30 - FRACTION_BITS));
      v.c2 = 32'(round_away(128'(rot[2][i]), 30 - FRACTION_BITS));
      t = round_away(-acc, 30);
      if (t > 128'sd2147483647) t = 128'sd2147483647;
      if (t < -128'sd2147483648) t = -128'sd2147483648;
      v.c3 = 32'(t);
      v.row = 2'(i);
      v.last = 0;
      expected_rows.push_back(v);
    end
    v.c0 = 0;
    v.c1 = 0;
    v.c2 = 0;
    v.c3 = 32'sd1 <<< FRACTION_BITS;
    v.row = 2'd3;
    v.last = 1;
    expected_rows.push_back(v);
  endtask

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  initial begin
    errors = 0;
    rows_seen = 0;
    saturated_rows = 0;
    pending_rows = 0;
  end

  always @(posedge clk) begin
    view_row_t e;
    if (rst_n && out_valid) begin
      rows_seen++;
      if (expected_rows.size() == 0) begin
        $error("unexpected row %0d with no request pending", out_row_index);
        errors++;
      end else begin
        e = expected_rows.pop_front();
        if (e.c3 == 32'sh7fffffff || e.c3 == 32'sh80000000) saturated_rows++;
        check_field("elem_c0", e.c0, out_elem_c0);
        check_field("elem_c1", e.c1, out_elem_c1);
        check_field("elem_c2", e.c2, out_elem_c2);
        check_field("elem_c3", e.c3, out_elem_c3);
        check_field("row_index", e.row, out_row_index);
        check_field("last_row", e.last, out_last_row);
      end
    end
    if (rst_n && start && !busy) predict_view_rows();
    pending_rows = expected_rows.size();
  end
endmodule

>>> tb/look_in_direction_view_matrix_top_tb.sv
// Testbench top: drives camera requests into the view matrix block and reports the verdict.
`timescale 1ns / 1ps
module look_in_direction_view_matrix_top_tb;
  localparam int RANDOM_REQUESTS = 440;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic signed [31:0] in_pos_x = 0, in_pos_y = 0, in_pos_z = 0;
  logic signed [15:0] in_angle_direction = 0, in_angle_elevation = 0, in_angle_roll = 0;
  logic out_valid;
  logic signed [31:0] out_elem_c0, out_elem_c1, out_elem_c2, out_elem_c3;
  logic [1:0] out_row_index;
  logic out_last_row;
  int errors, pending_rows, rows_seen, saturated_rows;
  int cycle_count = 0;
  int requests_sent = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  look_in_direction_view_matrix_top DUT (.*);

  look_in_direction_view_matrix_checker CHK (.*);

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // present one request, hold it until accepted
  task automatic send_request(logic signed [31:0] px, py, pz,
                              logic signed [15:0] ad, ae, ar);
    in_pos_x = px;
    in_pos_y = py;
    in_pos_z = pz;
    in_angle_direction = ad;
    in_angle_elevation = ae;
    in_angle_roll = ar;
    start = 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    start = 0;
    requests_sent++;
  endtask

  task automatic send_gap(bit allow);
    int n;
    if (allow && $urandom_range(0, 2) == 0) begin
      n = $urandom_range(1, 6);
      repeat (n) @(negedge clk);
    end
  endtask

  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'(12868 * ($urandom_range(0, 1) ? 1 : -1)); // near pi/2
      3: return 16'(25736 * ($urandom_range(0, 1) ? 1 : -1)); // near pi
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_pos();
    case ($urandom_range(0, 4))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'($signed(16'($urandom))); // small
      default: return 32'($urandom);
    endcase
  endfunction

  initial begin
    repeat (12) @(negedge clk);
    rst_n = 1;
    @(negedge clk);
    // directed: zero, extremes, quadrant boundaries, saturation
    send_request(0, 0, 0, 0, 0, 0);
    send_request(32'sh00010000, 32'sh00020000, 32'sh00030000, 0, 0, 0);
    send_request(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 0);
    send_request(32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0, 0);
    send_request(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_request(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_request(32'sh12345678, -32'sh00abcdef, 32'sh00001000, 12868, 0, 0);
    send_request(32'sh00100000, 32'sh00100000, 32'sh00100000, 0, 12868, 0);
    send_request(32'sh00100000, 32'sh00100000, 32'sh00100000, 0, 0, 12868);
    send_request(-32'sh00050000, 32'sh0, 32'sh00050000, 25736, -25736, 25735);
    send_request(32'sh0, 32'sh0, 32'sh0, 25737, 25738, -25737);
    send_request(32'sh40000000, 32'sh40000000, 32'sh40000000, -12868, 12869, -12867);
    send_request(32'sh7fffffff, 0, 0, 16'sh4000, -16'sh4000, 16'sh2000);
    send_request(32'shffffffff, 32'sh00000001, 32'shfffffffe, 1, -1, 16'sh5555);
    send_request(32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa, 16'shaaaa, 16'sh5555, 16'shaaaa);
    // hold off until every expected row has drained
    while (pending_rows != 0) @(negedge clk);
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      send_gap(i < RANDOM_REQUESTS - 60);
      send_request(rand_pos(), rand_pos(), rand_pos(), rand_angle(), rand_angle(), rand_angle());
      if (i == RANDOM_REQUESTS / 2)
        while (pending_rows != 0) @(negedge clk);
    end
    while (pending_rows != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("covered %0d camera requests, %0d view rows checked, %0d saturated translations",
             requests_sent, rows_seen, saturated_rows);
    if (errors == 0 && pending_rows == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
